// ===== rtl/gpi_pkg.sv =====
// Package for the gravity pull and Euler integration block.
// Item types, register indexes, sequencer states and saturation helpers.
// No dependencies.
package gpi_pkg;

    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 32;

    localparam logic [CfgIdxW-1:0] CFG_GRAV_CONST  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_SPEED_LIMIT = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_CLAMP_SPEED = 2'd2;

    localparam logic [30:0] GRAV_CONST_RST  = 31'd65536;
    localparam logic [30:0] SPEED_LIMIT_RST = 31'd26214;
    localparam logic [30:0] CLAMP_SPEED_RST = 31'd19661;

    localparam logic [1:0] OP_LOAD      = 2'd0;
    localparam logic [1:0] OP_PULL      = 2'd1;
    localparam logic [1:0] OP_SET_ACC   = 2'd2;
    localparam logic [1:0] OP_INTEGRATE = 2'd3;

    localparam logic [32:0] PULL_CAP = 33'h1_0000_0000;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] other_x;
        logic signed [31:0] other_y;
        logic [30:0]        other_mass;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] acc_x;
        logic signed [31:0] acc_y;
    } out_item_t;

    typedef enum logic [14:0] {
        ST_IDLE  = 15'b000000000000001,
        ST_VEL   = 15'b000000000000010,
        ST_SQ0   = 15'b000000000000100,
        ST_SQ1   = 15'b000000000001000,
        ST_KM    = 15'b000000000010000,
        ST_ROOT  = 15'b000000000100000,
        ST_D2    = 15'b000000001000000,
        ST_D3L   = 15'b000000010000000,
        ST_D3H   = 15'b000000100000000,
        ST_NUML  = 15'b000001000000000,
        ST_NUMH  = 15'b000010000000000,
        ST_DIV   = 15'b000100000000000,
        ST_APPLY = 15'b001000000000000,
        ST_POS   = 15'b010000000000000,
        ST_DONE  = 15'b100000000000000
    } state_t;

    // saturate a 34-bit signed sum to 32 bits
    function automatic logic signed [31:0] sat34(input logic signed [33:0] s);
        logic signed [31:0] r;
        if (s > 34'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (s < -34'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = s[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
        logic signed [33:0] s;
        s = {{2{a[31]}}, a} + {{2{b[31]}}, b};
        return sat34(s);
    endfunction

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        logic [32:0] r;
        r = v[32] ? (~v + 33'd1) : v;
        return r;
    endfunction

endpackage

// ===== rtl/gravity_pull_and_integrate.sv =====
// Top level: one body under gravity pulls, Euler integration, Q16.16.
// Shared 34x34 multiplier, bit-serial square root and divider under one sequencer.
// Depends on gpi_pkg.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+---------------------------------
//  in      | in  | in_valid / in_ready   | in_item  (gpi_pkg::in_item_t)
//  out     | out | out_valid / out_ready | out_item (gpi_pkg::out_item_t)
//  cfg     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Load, set acceleration and a zero-distance pull go straight to done; a pull and
// a clamped integrate run a 35-step square root and two 36-step divisions, an
// unclamped one neither. One item at a time: in_ready is high only in idle.
// The result sits in an output register; a new item is taken while it waits.
// Reset gives zero state and default registers; cfg_ready is always high.
module gravity_pull_and_integrate (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  gpi_pkg::in_item_t             in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output gpi_pkg::out_item_t            out_item,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gpi_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [gpi_pkg::CfgDataW-1:0]  cfg_data
);
    import gpi_pkg::*;

    state_t state_reg, state_next;

    logic [30:0] grav_reg, limit_reg, clamp_reg;
    logic signed [31:0] pos_x_reg, pos_y_reg, vel_x_reg, vel_y_reg, acc_x_reg, acc_y_reg;
    logic        pull_reg, comp_reg;
    logic [5:0]  cnt_reg;
    logic [30:0] mass_reg;
    logic [32:0] dmx_reg, dmy_reg;
    logic        sx_reg, sy_reg;
    logic [65:0] sq_reg;
    logic [61:0] km_reg;
    logic [33:0] root_reg;
    logic [67:0] d2_reg;
    logic [101:0] d3_reg;
    logic [95:0] num_reg;
    logic [111:0] rem_reg;
    logic [136:0] den_reg;
    logic [35:0] quo_reg;
    logic [65:0] sr_op_reg;
    logic [69:0] sr_res_reg, sr_one_reg;
    out_item_t   out_reg;
    logic        out_valid_reg;

    logic [33:0] mul_a, mul_b;
    logic [67:0] prod;
    logic [32:0] xmag, ymag, cmag;
    logic signed [32:0] dx, dy;
    logic [69:0] sr_t;
    logic        sr_ge;
    logic [69:0] sr_op_new, sr_res_new;
    logic        dv_ge;
    logic [95:0] num_sum;
    logic [101:0] den_src;
    logic [32:0] pull_mag;
    logic signed [33:0] pull_val, acc_sum;
    logic signed [31:0] acc_cur, vel_cur, clamp_val;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    assign dx = {in_item.other_x[31], in_item.other_x} - {pos_x_reg[31], pos_x_reg};
    assign dy = {in_item.other_y[31], in_item.other_y} - {pos_y_reg[31], pos_y_reg};

    assign xmag = pull_reg ? dmx_reg : mag33({vel_x_reg[31], vel_x_reg});
    assign ymag = pull_reg ? dmy_reg : mag33({vel_y_reg[31], vel_y_reg});
    assign cmag = comp_reg ? ymag : xmag;

    // shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQ0:
            begin
                mul_a = {1'b0, xmag};
                mul_b = {1'b0, xmag};
            end
            ST_SQ1:
            begin
                mul_a = {1'b0, ymag};
                mul_b = {1'b0, ymag};
            end
            ST_KM:
            begin
                mul_a = pull_reg ? {3'b0, grav_reg} : {3'b0, limit_reg};
                mul_b = pull_reg ? {3'b0, mass_reg} : {3'b0, limit_reg};
            end
            ST_D2:
            begin
                mul_a = root_reg;
                mul_b = root_reg;
            end
            ST_D3L:
            begin
                mul_a = d2_reg[33:0];
                mul_b = root_reg;
            end
            ST_D3H:
            begin
                mul_a = d2_reg[67:34];
                mul_b = root_reg;
            end
            ST_NUML:
            begin
                mul_a = pull_reg ? km_reg[33:0] : {3'b0, clamp_reg};
                mul_b = {1'b0, cmag};
            end
            ST_NUMH:
            begin
                mul_a = {6'b0, km_reg[61:34]};
                mul_b = {1'b0, cmag};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // square root step
    assign sr_t       = sr_res_reg + sr_one_reg;
    assign sr_ge      = {4'b0, sr_op_reg} >= sr_t;
    assign sr_op_new  = sr_ge ? ({4'b0, sr_op_reg} - sr_t) : {4'b0, sr_op_reg};
    assign sr_res_new = sr_ge ? ((sr_res_reg >> 1) + sr_one_reg) : (sr_res_reg >> 1);

    // divider step
    assign dv_ge = {25'b0, rem_reg} >= den_reg;

    assign num_sum = (state_reg == ST_NUMH) ? (num_reg + ({28'b0, prod} << 34))
                                            : {28'b0, prod};
    assign den_src = pull_reg ? d3_reg : {68'b0, root_reg};

    // pull apply
    assign pull_mag = (quo_reg[35] || (quo_reg[34:0] > {2'b0, PULL_CAP})) ? PULL_CAP
                                                                         : quo_reg[32:0];
    assign pull_val = (comp_reg ? sy_reg : sx_reg) ? -$signed({1'b0, pull_mag})
                                                   : $signed({1'b0, pull_mag});
    assign acc_cur  = comp_reg ? acc_y_reg : acc_x_reg;
    assign acc_sum  = {{2{acc_cur[31]}}, acc_cur} + pull_val;
    assign vel_cur  = comp_reg ? vel_y_reg : vel_x_reg;
    assign clamp_val = vel_cur[31] ? -$signed({1'b0, quo_reg[30:0]})
                                   : $signed({1'b0, quo_reg[30:0]});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_item.opcode)
                        OP_PULL:      state_next = (dx == '0 && dy == '0) ? ST_DONE : ST_SQ0;
                        OP_INTEGRATE: state_next = ST_VEL;
                        default:      state_next = ST_DONE;
                    endcase
                end
            end
            ST_VEL:  state_next = ST_SQ0;
            ST_SQ0:  state_next = ST_SQ1;
            ST_SQ1:  state_next = ST_KM;
            ST_KM:
            begin
                if (pull_reg || (sq_reg > {4'b0, prod[61:0]}))
                    state_next = ST_ROOT;
                else
                    state_next = ST_POS;
            end
            ST_ROOT:
            begin
                if (cnt_reg == 6'd34)
                    state_next = pull_reg ? ST_D2 : ST_NUML;
            end
            ST_D2:   state_next = ST_D3L;
            ST_D3L:  state_next = ST_D3H;
            ST_D3H:  state_next = ST_NUML;
            ST_NUML: state_next = pull_reg ? ST_NUMH : ST_DIV;
            ST_NUMH: state_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == 6'd35)
                    state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (!comp_reg)
                    state_next = ST_NUML;
                else
                    state_next = pull_reg ? ST_DONE : ST_POS;
            end
            ST_POS:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            grav_reg      <= GRAV_CONST_RST;
            limit_reg     <= SPEED_LIMIT_RST;
            clamp_reg     <= CLAMP_SPEED_RST;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            vel_x_reg     <= '0;
            vel_y_reg     <= '0;
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
            pull_reg      <= 1'b0;
            comp_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_GRAV_CONST:  grav_reg  <= cfg_data[30:0];
                    CFG_SPEED_LIMIT: limit_reg <= cfg_data[30:0];
                    CFG_CLAMP_SPEED: clamp_reg <= cfg_data[30:0];
                    default:         ;
                endcase
            end

            if (out_valid_reg && out_ready && state_reg != ST_DONE)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        pull_reg <= (in_item.opcode == OP_PULL);
                        comp_reg <= 1'b0;
                        mass_reg <= in_item.other_mass;
                        dmx_reg  <= mag33(dx);
                        dmy_reg  <= mag33(dy);
                        sx_reg   <= dx[32];
                        sy_reg   <= dy[32];
                        case (in_item.opcode)
                            OP_LOAD:
                            begin
                                pos_x_reg <= in_item.other_x;
                                pos_y_reg <= in_item.other_y;
                                vel_x_reg <= '0;
                                vel_y_reg <= '0;
                                acc_x_reg <= '0;
                                acc_y_reg <= '0;
                            end
                            OP_SET_ACC:
                            begin
                                acc_x_reg <= in_item.other_x;
                                acc_y_reg <= in_item.other_y;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_VEL:
                begin
                    vel_x_reg <= sat_add32(vel_x_reg, acc_x_reg);
                    vel_y_reg <= sat_add32(vel_y_reg, acc_y_reg);
                end
                ST_SQ0: sq_reg <= prod[65:0];
                ST_SQ1: sq_reg <= sq_reg + prod[65:0];
                ST_KM:
                begin
                    km_reg     <= prod[61:0];
                    sr_op_reg  <= sq_reg;
                    sr_res_reg <= '0;
                    sr_one_reg <= 70'd1 << 68;
                    cnt_reg    <= '0;
                end
                ST_ROOT:
                begin
                    sr_op_reg  <= sr_op_new[65:0];
                    sr_res_reg <= sr_res_new;
                    sr_one_reg <= sr_one_reg >> 2;
                    cnt_reg    <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd34)
                        root_reg <= sr_res_new[33:0];
                end
                ST_D2:  d2_reg <= prod;
                ST_D3L: d3_reg <= {34'b0, prod};
                ST_D3H: d3_reg <= d3_reg + ({34'b0, prod} << 34);
                ST_NUML, ST_NUMH:
                begin
                    num_reg <= num_sum;
                    rem_reg <= pull_reg ? ({16'b0, num_sum} << 16) : {16'b0, num_sum};
                    den_reg <= {35'b0, den_src} << 35;
                    quo_reg <= '0;
                    cnt_reg <= '0;
                end
                ST_DIV:
                begin
                    if (dv_ge)
                        rem_reg <= rem_reg - den_reg[111:0];
                    den_reg <= den_reg >> 1;
                    quo_reg <= {quo_reg[34:0], dv_ge};
                    cnt_reg <= cnt_reg + 6'd1;
                end
                ST_APPLY:
                begin
                    comp_reg <= 1'b1;
                    if (pull_reg)
                    begin
                        if (comp_reg)
                            acc_y_reg <= sat34(acc_sum);
                        else
                            acc_x_reg <= sat34(acc_sum);
                    end
                    else
                    begin
                        if (comp_reg)
                            vel_y_reg <= clamp_val;
                        else
                            vel_x_reg <= clamp_val;
                    end
                end
                ST_POS:
                begin
                    pos_x_reg <= sat_add32(pos_x_reg, vel_x_reg);
                    pos_y_reg <= sat_add32(pos_y_reg, vel_y_reg);
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg.pos_x <= pos_x_reg;
                        out_reg.pos_y <= pos_y_reg;
                        out_reg.vel_x <= vel_x_reg;
                        out_reg.vel_y <= vel_y_reg;
                        out_reg.acc_x <= acc_x_reg;
                        out_reg.acc_y <= acc_y_reg;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== bench/gravity_pull_and_integrate_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for gravity_pull_and_integrate: directed and random items
// against an in-bench body predictor, under several idle and stall mixes.
// Depends on gpi_pkg and the gravity_pull_and_integrate RTL.
module gravity_pull_and_integrate_test;
    import gpi_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_item_t in_item = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_item_t out_item;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    gravity_pull_and_integrate uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // body state and registers as the block should hold them
    logic signed [31:0] body_px, body_py, body_vx, body_vy, body_ax, body_ay;
    logic [30:0] k_grav, v_limit, v_clamp;

    out_item_t expected_states[$];
    int unsigned mismatch_count = 0;
    int unsigned items_sent = 0;
    int unsigned states_seen = 0;
    int unsigned clamp_count = 0;
    int unsigned pull_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic recv_hold = 1'b0;

    function automatic logic signed [31:0] sat64(input logic signed [63:0] s);
        if (s > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        else if (s < -64'sd2147483648)
            return 32'sh8000_0000;
        return s[31:0];
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [127:0] s);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 34; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (128'(t) * 128'(t) <= s)
                r = t;
        end
        return r;
    endfunction

    function automatic logic signed [63:0] pull_component(input logic [127:0] km,
                                                          input logic signed [32:0] d,
                                                          input logic [63:0] span);
        logic [32:0] mag;
        logic [127:0] q;
        mag = d[32] ? -d : d;
        q = ((km * 128'(mag)) << 16) / (128'(span) * 128'(span) * 128'(span));
        if (q > 128'h1_0000_0000)
            q = 128'h1_0000_0000;
        return d[32] ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

    function automatic logic signed [31:0] clamp_component(input logic signed [31:0] v,
                                                           input logic [63:0] speed);
        logic [63:0] mag;
        logic [63:0] m;
        mag = v[31] ? 64'(-65'(v)) : 64'(v);
        m = (64'(v_clamp) * mag) / speed;
        return v[31] ? -$signed(m[31:0]) : $signed(m[31:0]);
    endfunction

    function automatic out_item_t advance_body(input in_item_t it);
        logic signed [32:0] dx, dy;
        logic [32:0] adx, ady;
        logic [63:0] span, speed;
        logic [127:0] km, s;
        logic [63:0] avx, avy;
        out_item_t r;
        case (it.opcode)
            OP_LOAD:
            begin
                body_px = it.other_x;
                body_py = it.other_y;
                body_vx = '0;
                body_vy = '0;
                body_ax = '0;
                body_ay = '0;
            end
            OP_PULL:
            begin
                dx = 33'(it.other_x) - 33'(body_px);
                dy = 33'(it.other_y) - 33'(body_py);
                if (dx != 0 || dy != 0)
                begin
                    adx = dx[32] ? -dx : dx;
                    ady = dy[32] ? -dy : dy;
                    span = floor_sqrt(128'(adx) * 128'(adx) + 128'(ady) * 128'(ady));
                    km = 128'(k_grav) * 128'(it.other_mass);
                    body_ax = sat64(64'(body_ax) + pull_component(km, dx, span));
                    body_ay = sat64(64'(body_ay) + pull_component(km, dy, span));
                    pull_count++;
                end
            end
            OP_SET_ACC:
            begin
                body_ax = it.other_x;
                body_ay = it.other_y;
            end
            default:
            begin
                body_vx = sat64(64'(body_vx) + 64'(body_ax));
                body_vy = sat64(64'(body_vy) + 64'(body_ay));
                avx = body_vx[31] ? 64'(-65'(body_vx)) : 64'(body_vx);
                avy = body_vy[31] ? 64'(-65'(body_vy)) : 64'(body_vy);
                s = 128'(avx) * 128'(avx) + 128'(avy) * 128'(avy);
                if (s > 128'(v_limit) * 128'(v_limit))
                begin
                    speed = floor_sqrt(s);
                    body_vx = clamp_component(body_vx, speed);
                    body_vy = clamp_component(body_vy, speed);
                    clamp_count++;
                end
                body_px = sat64(64'(body_px) + 64'(body_vx));
                body_py = sat64(64'(body_py) + 64'(body_vy));
            end
        endcase
        r.pos_x = body_px;
        r.pos_y = body_py;
        r.vel_x = body_vx;
        r.vel_y = body_vy;
        r.acc_x = body_ax;
        r.acc_y = body_ay;
        return r;
    endfunction

    task automatic send_item(input in_item_t it);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_states.push_back(advance_body(it));
        items_sent++;
    endtask

    task automatic drain_states();
        in_valid <= 1'b0;
        while (expected_states.size() != 0)
            @(posedge clk);
        repeat (150)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_GRAV_CONST:  k_grav = data[30:0];
            CFG_SPEED_LIMIT: v_limit = data[30:0];
            CFG_CLAMP_SPEED: v_clamp = data[30:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(input logic [31:0] k, input logic [31:0] lim,
                            input logic [31:0] clp);
        drain_states();
        write_reg(CFG_GRAV_CONST, k);
        write_reg(CFG_SPEED_LIMIT, lim);
        write_reg(CFG_CLAMP_SPEED, clp);
    endtask

    function automatic in_item_t make_item(input logic [1:0] op, input logic [31:0] x,
                                           input logic [31:0] y, input logic [30:0] m);
        in_item_t it;
        it.opcode = op;
        it.other_x = x;
        it.other_y = y;
        it.other_mass = m;
        return it;
    endfunction

    function automatic logic [31:0] rand_coord();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(5))
            0: return v;
            1: return $signed(v) >>> $urandom_range(31, 8);
            2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            3: return $signed(v) >>> $urandom_range(20, 12);
            default: return $signed(v) >>> $urandom_range(31, 14);
        endcase
    endfunction

    function automatic logic [30:0] rand_mass();
        logic [30:0] v;
        v = 31'($urandom);
        case ($urandom_range(3))
            0: return v;
            1: return 31'd0;
            default: return v >> $urandom_range(30, 4);
        endcase
    endfunction

    // mostly orbits: load, pulls and integrates; the rest noise
    task automatic random_items(input int unsigned count);
        in_item_t it;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(19))
                0: it = make_item(OP_LOAD, rand_coord(), rand_coord(), rand_mass());
                1, 2: it = make_item(OP_SET_ACC, rand_coord(), rand_coord(), rand_mass());
                3, 4, 5, 6, 7, 8:
                begin
                    if ($urandom_range(9) == 0)
                        it = make_item(OP_PULL, body_px, body_py, rand_mass());
                    else if ($urandom_range(1))
                        it = make_item(OP_PULL, body_px + ($signed(32'($urandom)) >>> 8),
                                       body_py + ($signed(32'($urandom)) >>> 8),
                                       rand_mass());
                    else
                        it = make_item(OP_PULL, rand_coord(), rand_coord(), rand_mass());
                end
                default: it = make_item(OP_INTEGRATE, rand_coord(), rand_coord(), rand_mass());
            endcase
            send_item(it);
        end
    endtask

    task automatic test_directed();
        send_item(make_item(OP_INTEGRATE, 32'h0, 32'h0, 31'h0));
        send_item(make_item(OP_PULL, 32'h0, 32'h0, 31'h7FFF_FFFF));
        send_item(make_item(OP_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF));
        send_item(make_item(OP_PULL, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF));
        send_item(make_item(OP_PULL, 32'h7FFF_FFFF, 32'h8000_0000, 31'h10000));
        send_item(make_item(OP_PULL, 32'h7FFF_FFFE, 32'h8000_0000, 31'h7FFF_FFFF));
        send_item(make_item(OP_PULL, 32'h7FFF_FFFE, 32'h8000_0000, 31'h7FFF_FFFF));
        send_item(make_item(OP_PULL, 32'h0, 32'h0, 31'h0));
        send_item(make_item(OP_SET_ACC, 32'h7FFF_FFFF, 32'h8000_0000, 31'h0));
        send_item(make_item(OP_INTEGRATE, 32'h0, 32'h0, 31'h0));
        send_item(make_item(OP_INTEGRATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF));
        send_item(make_item(OP_LOAD, 32'h0, 32'h0, 31'h0));
        send_item(make_item(OP_SET_ACC, 32'h4000, 32'hFFFF_C000, 31'h0));
        send_item(make_item(OP_INTEGRATE, 32'h0, 32'h0, 31'h0));
        send_item(make_item(OP_INTEGRATE, 32'h0, 32'h0, 31'h0));
        send_item(make_item(OP_PULL, 32'h10000, 32'h0, 31'h10000));
        send_item(make_item(OP_INTEGRATE, 32'h0, 32'h0, 31'h0));
        set_regs(32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF);
        write_reg(2'd3, 32'h1234_5678);
        send_item(make_item(OP_SET_ACC, 32'h1, 32'h0, 31'h0));
        send_item(make_item(OP_INTEGRATE, 32'h0, 32'h0, 31'h0));
        send_item(make_item(OP_PULL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF));
        send_item(make_item(OP_INTEGRATE, 32'h0, 32'h0, 31'h0));
        set_regs(32'h0, 32'h7FFF_FFFF, 32'h0);
        send_item(make_item(OP_PULL, 32'h100, 32'h100, 31'h7FFF_FFFF));
        send_item(make_item(OP_INTEGRATE, 32'h0, 32'h0, 31'h0));
    endtask

    task automatic test_idle_mixes();
        send_idle_pct = 0;  recv_stall_pct = 0;
        set_regs(32'd65536, 32'd26214, 32'd19661);
        random_items(250);
        send_idle_pct = 66; recv_stall_pct = 0;
        set_regs($urandom, $urandom, $urandom);
        random_items(250);
        send_idle_pct = 0;  recv_stall_pct = 66;
        set_regs(32'd1 << $urandom_range(24), 32'd1 << $urandom_range(30), $urandom);
        random_items(250);
        send_idle_pct = 12; recv_stall_pct = 12;
        set_regs(32'd65536, 32'd65536 << $urandom_range(8), 32'd19661);
        random_items(250);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;  recv_stall_pct = 0;
        drain_states();
        fork
            begin
                recv_hold = 1'b1;
                for (int c = 0; c < 1500; c++)
                    @(posedge clk);
                recv_hold = 1'b0;
            end
            random_items(8);
        join
        drain_states();
        random_items(20);
    endtask

    always @(posedge clk)
        out_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        out_item_t e;
        if (rst_n && out_valid && out_ready)
        begin
            states_seen++;
            if (expected_states.size() == 0)
            begin
                $display("%0t: unexpected item, actual %h", $time, out_item);
                mismatch_count++;
            end
            else
            begin
                e = expected_states.pop_front();
                check_field("pos_x", e.pos_x, out_item.pos_x);
                check_field("pos_y", e.pos_y, out_item.pos_y);
                check_field("vel_x", e.vel_x, out_item.vel_x);
                check_field("vel_y", e.vel_y, out_item.vel_y);
                check_field("acc_x", e.acc_x, out_item.acc_x);
                check_field("acc_y", e.acc_y, out_item.acc_y);
            end
        end
    end

    initial
    begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int unsigned waited;
        k_grav = GRAV_CONST_RST;
        v_limit = SPEED_LIMIT_RST;
        v_clamp = CLAMP_SPEED_RST;
        {body_px, body_py, body_vx, body_vy, body_ax, body_ay} = '0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_idle_mixes();
        test_backpressure();
        in_valid <= 1'b0;
        waited = 0;
        while (expected_states.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (200)
            @(posedge clk);
        $display("Covered %0d items and %0d states checked: %0d pulls, %0d clamps,",
                 items_sent, states_seen, pull_count, clamp_count);
        $display("four idle mixes, register sweeps and a long output hold-off.");
        if (mismatch_count == 0 && expected_states.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
